// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the framer RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property checked at every rising edge, disabled while reset is low
`define ASSERT_AR(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition that must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_AR(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ----- rtl/nsfc_pkg.sv -----
// Types, codes and helper functions for the sentence framer/checker.
// No dependencies; used by every module of the block.
package nsfc_pkg;

	localparam int unsigned CNT_W = 8;
	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_LF = 8'd10;
	localparam logic [CNT_W-1:0] MIN_LINE = 8'd8;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_MISMATCH  = 3'd1,
		ST_BAD_HEX   = 3'd2,
		ST_TOO_SHORT = 3'd3,
		ST_OVERFLOW  = 3'd4
	} line_status_t;

	typedef enum logic [1:0] {
		KIND_UNKNOWN = 2'd0,
		KIND_GGA     = 2'd1,
		KIND_VTG     = 2'd2,
		KIND_GSV     = 2'd3
	} sentence_kind_t;

	// what the tracker knows about the line at the byte being taken
	typedef struct packed {
		logic             line_end;
		sentence_kind_t   kind;
		logic [7:0]       csum;
		logic [7:0]       hi_char;
		logic [7:0]       lo_char;
		logic [CNT_W-1:0] length;
		logic             overflow;
		logic             too_short;
	} line_info_t;

	localparam logic [39:0] NAME_GGA = "GPGGA";
	localparam logic [39:0] NAME_VTG = "GPVTG";
	localparam logic [39:0] NAME_GSV = "GPGSV";

	// character idx (0 = first) of sentence name k (0 GGA, 1 VTG, 2 GSV)
	function automatic logic [7:0] kind_char(input logic [1:0] k, input logic [2:0] idx);
		logic [39:0] name;
		logic [7:0]  c;
		case (k)
			2'd0:    name = NAME_GGA;
			2'd1:    name = NAME_VTG;
			default: name = NAME_GSV;
		endcase
		case (idx)
			3'd0:    c = name[39:32];
			3'd1:    c = name[31:24];
			3'd2:    c = name[23:16];
			3'd3:    c = name[15:8];
			default: c = name[7:0];
		endcase
		return c;
	endfunction

	// returns {digit ok, nibble}
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		if (c inside {["0":"9"]}) begin
			r = {1'b1, 4'(c - "0")};
		end else if (c inside {["A":"F"]}) begin
			r = {1'b1, 4'(c - "A" + 8'd10)};
		end else if (c inside {["a":"f"]}) begin
			r = {1'b1, 4'(c - "a" + 8'd10)};
		end else begin
			r = 5'd0;
		end
		return r;
	endfunction

endpackage

// ----- rtl/nsfc_line_tracker.sv -----
// Per-line state: running XOR, byte count, recent-byte history, name match.
// Depends on nsfc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module nsfc_line_tracker import nsfc_pkg::*; #(
	parameter int LINE_CAPACITY = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] byte_in,
	output line_info_t info
);

	localparam logic [CNT_W-1:0] CAP = CNT_W'(LINE_CAPACITY);

	logic [7:0]       xor_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0]       recent_q [5];
	logic [2:0]       flags_q;
	logic             ovf_q;

	logic [7:0]       xor_n;
	logic [CNT_W-1:0] count_n;
	logic [2:0]       flags_n;
	logic             ovf_n;
	logic [2:0]       idx;
	logic             in_name;

	always_comb begin
		idx     = count_q[2:0] - 3'd1;
		in_name = (count_q != '0) && (count_q <= CNT_W'(5));
		flags_n = flags_q;
		for (int k = 0; k < 3; k++) begin
			if (in_name && kind_char(2'(k), idx) != byte_in) begin
				flags_n[k] = 1'b0;
			end
		end
		xor_n   = (count_q != '0) ? (xor_q ^ byte_in) : xor_q;
		count_n = (count_q < CAP) ? count_q + 1'b1 : count_q;
		ovf_n   = ovf_q | (count_q >= CAP);
	end

	always_comb begin
		info.line_end = (count_q != '0) && (byte_in == CH_LF) && (recent_q[0] == CH_CR);
		if (flags_n[0]) begin
			info.kind = KIND_GGA;
		end else if (flags_n[1]) begin
			info.kind = KIND_VTG;
		end else if (flags_n[2]) begin
			info.kind = KIND_GSV;
		end else begin
			info.kind = KIND_UNKNOWN;
		end
		// strip star, both digits, CR and LF back out of the XOR
		info.csum      = xor_n ^ byte_in ^ recent_q[0] ^ recent_q[1] ^ recent_q[2] ^ recent_q[3];
		info.hi_char   = recent_q[2];
		info.lo_char   = recent_q[1];
		info.length    = count_n;
		info.overflow  = ovf_n;
		info.too_short = count_n < MIN_LINE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xor_q   <= '0;
			count_q <= '0;
			flags_q <= 3'b111;
			ovf_q   <= 1'b0;
			for (int i = 0; i < 5; i++) begin
				recent_q[i] <= '0;
			end
		end else if (take) begin
			recent_q[0] <= byte_in;
			for (int i = 1; i < 5; i++) begin
				recent_q[i] <= recent_q[i-1];
			end
			if (info.line_end) begin
				xor_q   <= '0;
				count_q <= '0;
				flags_q <= 3'b111;
				ovf_q   <= 1'b0;
			end else begin
				xor_q   <= xor_n;
				count_q <= count_n;
				flags_q <= flags_n;
				ovf_q   <= ovf_n;
			end
		end
	end

	`ASSERT_NEVER(a_count_le_cap, clk, arst_n, count_q > CAP, "byte count above capacity")
	`ASSERT_AR(a_ovf_full, clk, arst_n, ovf_q |-> (count_q == CAP), "overflow without full line")

endmodule

// ----- rtl/nsfc_result_reg.sv -----
// Result stage: status priority, hex decode and the output register.
// Depends on nsfc_pkg.
module nsfc_result_reg import nsfc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  line_info_t info,
	input  logic       out_ready,
	output logic       out_valid,
	output logic       free,
	output logic [2:0] line_status,
	output logic [1:0] sentence_kind,
	output logic [7:0] received_sum,
	output logic [7:0] computed_sum,
	output logic [7:0] line_length
);

	logic [4:0]   hi_d;
	logic [4:0]   lo_d;
	line_status_t st;
	logic [7:0]   rsum;
	logic [7:0]   csum;

	always_comb begin
		hi_d = hex_decode(info.hi_char);
		lo_d = hex_decode(info.lo_char);
		csum = info.csum;
		if (!hi_d[4] || !lo_d[4]) begin
			rsum = '0;
			st   = ST_BAD_HEX;
		end else begin
			rsum = {hi_d[3:0], lo_d[3:0]};
			st   = (rsum == csum) ? ST_OK : ST_MISMATCH;
		end
		if (info.too_short) begin
			st   = ST_TOO_SHORT;
			rsum = '0;
			csum = '0;
		end
		if (info.overflow) begin
			st = ST_OVERFLOW;
		end
	end

	assign free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			line_status   <= st;
			sentence_kind <= info.kind;
			received_sum  <= rsum;
			computed_sum  <= csum;
			line_length   <= info.length;
		end
	end

endmodule

// ----- rtl/nmea_sentence_framer_checker_unit.sv -----
// Top level of the sentence framer/checker: input register, line tracker,
// result register. Depends on nsfc_pkg, nsfc_line_tracker, nsfc_result_reg.
//
// Usage
//   Input channel (in_valid/in_ready/rx_byte) takes one received character
//   per transfer. Output channel (out_valid/out_ready) gives one result per
//   line that ends in CR LF: line_status, sentence_kind, received_sum,
//   computed_sum and line_length. Bytes that do not end a line give nothing.
//   Throughput: one byte per cycle while no line-ending LF is stalled. A
//   byte first sits in the input register, then updates the line state; a
//   line-ending LF loads the result register as it updates the line state,
//   which sets out_valid. Running XOR, count and name-match update per byte.
//   Stall: a waiting result does not block bytes that end no line; only a
//   LF that ends a line waits in the input register until the result
//   register is free, and in_ready drops while it waits.
//   Reset (arst_n low) empties both registers, clears the XOR, the count,
//   the overflow flag and the byte history, and reopens all three names.
//   Lines longer than LINE_CAPACITY bytes are kept framing; length
//   saturates and the line reports overflow at its CR LF.
`include "assert_macros.svh"
module nmea_sentence_framer_checker_unit import nsfc_pkg::*; #(
	parameter int LINE_CAPACITY = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] line_status,
	output logic [1:0] sentence_kind,
	output logic [7:0] received_sum,
	output logic [7:0] computed_sum,
	output logic [7:0] line_length
);

	logic [7:0] rx_byte_s1;
	logic       valid_s1;
	line_info_t info;
	logic       res_free;
	logic       take;

	// advance the held byte unless it ends a line and the result slot is full
	assign take     = valid_s1 && (!info.line_end || res_free);
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// hold the byte until it advances
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	nsfc_line_tracker #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_tracker (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.byte_in (rx_byte_s1),
		.info    (info)
	);

	nsfc_result_reg u_result (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (take && info.line_end),
		.info          (info),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.free          (res_free),
		.line_status   (line_status),
		.sentence_kind (sentence_kind),
		.received_sum  (received_sum),
		.computed_sum  (computed_sum),
		.line_length   (line_length)
	);

	`ASSERT_AR(a_ok_sums_match, clk, arst_n,
		(out_valid && line_status == ST_OK) |-> (received_sum == computed_sum),
		"ok status with differing sums")
	`ASSERT_AR(a_short_zero, clk, arst_n,
		(out_valid && line_status == ST_TOO_SHORT) |-> (received_sum == 8'd0 && computed_sum == 8'd0),
		"short line with nonzero sums")
	`ASSERT_AR(a_ovf_len, clk, arst_n,
		(out_valid && line_status == ST_OVERFLOW) |-> (line_length == 8'(LINE_CAPACITY)),
		"overflow line without saturated length")

endmodule
